FILE: hdl/ppq_pkg.sv
// ----------------------------------------------------------------------------
// ppq_pkg
// shared types and constants of the priority process queue
// ----------------------------------------------------------------------------
package ppq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int ID_W        = 16;
   localparam int DUR_W       = 16;
   localparam int PRI_W       = 8;
   localparam int QCOUNT_W    = 5;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 48;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_SCHED = 1'b1;

   typedef struct packed {
      logic [PRI_W-1:0] pri;
      logic [DUR_W-1:0] dur;
      logic [ID_W-1:0]  id;
   } entry_type;

   typedef struct packed {
      entry_type        entry;
      logic [IDX_W-1:0] idx;
   } best_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

endpackage

FILE: hdl/ppq_cell.sv
// ----------------------------------------------------------------------------
// ppq_cell
// one queue slot: holds an entry and passes the running best to its neighbor
// ----------------------------------------------------------------------------
module ppq_cell
   import ppq_pkg::*;
(
   input  logic             clock,
   input  cell_ctl_type     ctl,
   input  logic [IDX_W-1:0] cell_index,
   input  logic             occupied,
   input  entry_type        new_entry,
   input  entry_type        right_entry,
   input  best_type         left_best,
   output entry_type        entry,
   output best_type         best
);

   entry_type entry_ff, entry_in;
   best_type  best_ff, best_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.shift) begin
         entry_in = right_entry;
      end else if (ctl.load) begin
         entry_in = new_entry;
      end
   end

   // strict compare keeps the lower index on a tie
   always_comb begin
      best_in = left_best;
      if (occupied && (entry_ff.pri > left_best.entry.pri)) begin
         best_in.entry = entry_ff;
         best_in.idx   = cell_index;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      best_ff  <= best_in;
   end

   assign entry = entry_ff;
   assign best  = best_ff;

endmodule

FILE: hdl/priority_process_queue.sv
// ----------------------------------------------------------------------------
// priority_process_queue
// bounded process queue built as a row of cells with a best-entry wavefront
// ----------------------------------------------------------------------------
// add beat: registered the cycle after acceptance, one per cycle unless rsp stalls
// schedule beat: result set by the wavefront once it has crossed the cell row
// no new beat is taken while a schedule is in progress
// synchronous active-high reset empties the queue and clears the current process
// ----------------------------------------------------------------------------
module priority_process_queue
   import ppq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // proc_id, proc_duration, proc_priority
   input  logic [0:0]            req_tuser,  // opcode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // accepted, current_valid, current_id,
                                             // current_duration, current_priority,
                                             // queue_count
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic                  state_ff, state_in;
   logic [IDX_W-1:0]      cnt_ff, cnt_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   entry_type             cur_ff, cur_in;
   logic                  cur_valid_ff, cur_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   entry_type    entry_w [QUEUE_DEPTH];
   best_type     best_w  [QUEUE_DEPTH];
   cell_ctl_type ctl_w   [QUEUE_DEPTH];
   logic         occ_w   [QUEUE_DEPTH];

   entry_type new_entry;
   best_type  last_best;
   logic      out_free, req_accept, is_add, full, add_ok;
   logic      scan_done, found, commit, rsp_load, acc_bit;

   assign new_entry  = entry_type'(req_tdata);
   assign last_best  = best_w[QUEUE_DEPTH-1];
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_accept = req_tvalid && req_tready;
   assign is_add     = (req_tuser[0] == OP_ADD);
   assign full       = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign add_ok     = req_accept && is_add && !full;
   assign scan_done  = (state_ff == ST_SCAN) && (cnt_ff == IDX_W'(QUEUE_DEPTH - 1)) && out_free;
   assign found      = (last_best.entry.pri != '0);
   assign commit     = scan_done && found;
   assign rsp_load   = (req_accept && is_add) || scan_done;
   assign acc_bit    = (state_ff == ST_SCAN) ? found : !full;

   for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      best_type  left_best;
      entry_type right_entry;

      assign occ_w[k]       = (count_ff > COUNT_W'(k));
      assign ctl_w[k].load  = add_ok && (count_ff == COUNT_W'(k));
      assign ctl_w[k].shift = commit && occ_w[k] && (IDX_W'(k) >= last_best.idx);

      if (k == 0) begin : g_first
         assign left_best = '0;
      end else begin : g_mid
         assign left_best = best_w[k-1];
      end
      if (k == QUEUE_DEPTH - 1) begin : g_last
         assign right_entry = entry_w[k];
      end else begin : g_inner
         assign right_entry = entry_w[k+1];
      end

      ppq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl_w[k]),
         .cell_index  (IDX_W'(k)),
         .occupied    (occ_w[k]),
         .new_entry   (new_entry),
         .right_entry (right_entry),
         .left_best   (left_best),
         .entry       (entry_w[k]),
         .best        (best_w[k])
      );
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      if (req_accept) begin
         cnt_in = '0;
         if (!is_add) begin
            state_in = ST_SCAN;
         end
      end else if (scan_done) begin
         state_in = ST_IDLE;
      end else if ((state_ff == ST_SCAN) && (cnt_ff != IDX_W'(QUEUE_DEPTH - 1))) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_comb begin
      count_in     = count_ff;
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      if (add_ok) begin
         count_in = count_ff + 1'b1;
      end else if (commit) begin
         count_in     = count_ff - 1'b1;
         cur_in       = last_best.entry;
         cur_valid_in = 1'b1;
      end
   end

   always_comb begin
      rsp_data_in  = {1'b0, QCOUNT_W'(count_in), cur_in.pri, cur_in.dur, cur_in.id,
                      cur_valid_in, acc_bit};
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         count_ff     <= '0;
         cur_ff       <= '0;
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         count_ff     <= count_in;
         cur_ff       <= cur_in;
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: hdl/ppq_checker.sv
// ----------------------------------------------------------------------------
// ppq_checker
// port-level checks of the priority process queue
// ----------------------------------------------------------------------------
module ppq_checker
   import ppq_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata   // accepted, current_valid, current_id,
                                            // current_duration, current_priority,
                                            // queue_count
);

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp beat after reset");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[46:42] <= QCOUNT_W'(QUEUE_DEPTH)) || (QUEUE_DEPTH > 31))
      else $error("queue count beyond depth");

   a_idle_current_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |-> (rsp_tdata[41:2] == '0))
      else $error("current fields set with no process scheduled");

   a_sched_priority: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> (rsp_tdata[41:34] != '0))
      else $error("scheduled process with zero priority");

endmodule

bind priority_process_queue ppq_checker u_ppq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
